/* hdl/string_containment_classifier_core_defines.svh */
// Assertion macros shared by the checker of the string containment classifier.
// Depends on nothing; included by the checker file.
`ifndef STRING_CONTAINMENT_CLASSIFIER_CORE_DEFINES_SVH
`define STRING_CONTAINMENT_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define SCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scc check failed");

// Next-cycle implication, quiet while reset is high.
`define SCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scc check failed");

// Next-cycle implication that also holds across reset.
`define SCC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("scc check failed");

`endif

/* hdl/scc_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the
// string containment classifier. Depends on nothing.
`default_nettype none

package scc_pkg;

   // Longest string held; longer strings are cut and their lengths saturate.
   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   // Failure entries hold -1 .. MAX_LEN-1.
   localparam int FAIL_W  = ADDR_W + 1;
   // The match pointer also reaches the pattern length itself.
   localparam int K_W     = LEN_W + 1;
   localparam int CHAR_W  = 8;
   localparam int REL_W   = 3;

   // Input item kind.
   localparam logic KIND_REF = 1'b0;

   // Relation codes returned per finished query.
   typedef enum logic [REL_W-1:0] {
      REL_Q_HAS_R = 3'd0,
      REL_Q_NOT_R = 3'd1,
      REL_R_HAS_Q = 3'd2,
      REL_R_NOT_Q = 3'd3,
      REL_EQUAL   = 3'd4,
      REL_DIFFER  = 3'd5
   } relation_type;

   // Operations of the search engine.
   typedef enum logic [2:0] {
      OP_BUILD_REF = 3'd0,
      OP_BUILD_QRY = 3'd1,
      OP_SCAN_QT   = 3'd2,
      OP_SCAN_RT   = 3'd3,
      OP_EQ        = 3'd4
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic   load_ref;
      logic   load_query;
      logic   clear_query;
      logic   init;
      logic   eval;
      logic   set_ref_complete;
      op_type op;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ref_complete;
      logic q_longer;
      logic r_longer;
      logic done;
      logic found;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/scc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/scc_datapath.sv */
// Datapath of the classifier: string and failure-table memories, lengths,
// and the KMP pointer registers with their step logic. Depends on scc_pkg, scc_ram.
`default_nettype none

module scc_datapath import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] req_char_byte,
   input  dp_cmd_type        cmd,
   output dp_status_type     status
);

   logic [LEN_W-1:0]         ref_len_ff, ref_len_in;
   logic [LEN_W-1:0]         qry_len_ff, qry_len_in;
   logic                     ref_done_ff, ref_done_in;
   logic [LEN_W-1:0]         i_ff, i_in;
   logic signed [K_W-1:0]    k_ff, k_in;

   logic                     ref_we, qry_we;
   logic [ADDR_W-1:0]        ref_waddr;
   logic [ADDR_W-1:0]        i_addr, k_addr;
   logic [CHAR_W-1:0]        ref_txt_rd, ref_pat_rd, qry_txt_rd, qry_pat_rd;
   logic signed [FAIL_W-1:0] ref_fail_rd, qry_fail_rd, fail_k;

   logic                     fail_we;
   logic [ADDR_W-1:0]        fail_waddr;
   logic [FAIL_W-1:0]        fail_wdata;

   logic                     txt_q, pat_q, is_build, is_eq, hit, done, found;
   logic [CHAR_W-1:0]        txt_ch, pat_ch;
   logic [LEN_W-1:0]         tlen, plen, i_nx;
   logic signed [K_W-1:0]    k_nx;

   assign i_addr = i_ff[ADDR_W-1:0];
   assign k_addr = k_ff[ADDR_W-1:0];

   // Reference length: a byte after a finished reference starts a new one.
   always_comb begin
      ref_len_in  = ref_len_ff;
      ref_done_in = ref_done_ff;
      ref_we      = 1'b0;
      ref_waddr   = ref_len_ff[ADDR_W-1:0];
      if (cmd.load_ref) begin
         ref_done_in = 1'b0;
         if (ref_done_ff) begin
            ref_we     = 1'b1;
            ref_waddr  = '0;
            ref_len_in = LEN_W'(1);
         end else if (ref_len_ff < LEN_W'(MAX_LEN)) begin
            ref_we     = 1'b1;
            ref_len_in = ref_len_ff + LEN_W'(1);
         end
      end
      if (cmd.set_ref_complete) begin
         ref_done_in = 1'b1;
      end
   end

   // Query length; clearing wins over loading.
   always_comb begin
      qry_len_in = qry_len_ff;
      qry_we     = 1'b0;
      if (cmd.clear_query) begin
         qry_len_in = '0;
      end else if (cmd.load_query && (qry_len_ff < LEN_W'(MAX_LEN))) begin
         qry_we     = 1'b1;
         qry_len_in = qry_len_ff + LEN_W'(1);
      end
   end

   // Operand routing for the running operation.
   assign txt_q    = (cmd.op == OP_BUILD_QRY) || (cmd.op == OP_SCAN_QT) || (cmd.op == OP_EQ);
   assign pat_q    = (cmd.op == OP_BUILD_QRY) || (cmd.op == OP_SCAN_RT);
   assign is_build = (cmd.op == OP_BUILD_REF) || (cmd.op == OP_BUILD_QRY);
   assign is_eq    = (cmd.op == OP_EQ);
   assign txt_ch   = txt_q ? qry_txt_rd : ref_txt_rd;
   assign pat_ch   = pat_q ? qry_pat_rd : ref_pat_rd;
   assign fail_k   = pat_q ? qry_fail_rd : ref_fail_rd;
   assign tlen     = txt_q ? qry_len_ff : ref_len_ff;
   assign plen     = pat_q ? qry_len_ff : ref_len_ff;
   assign i_nx     = i_ff + LEN_W'(1);
   assign k_nx     = k_ff + $signed(K_W'(1));
   assign hit      = k_ff[K_W-1] || (txt_ch == pat_ch);

   // One KMP step: advance both pointers on a match, else fall back or end an OP_EQ test.
   always_comb begin
      i_in       = i_ff;
      k_in       = k_ff;
      fail_we    = 1'b0;
      fail_waddr = i_nx[ADDR_W-1:0];
      fail_wdata = FAIL_W'(k_nx);
      done       = 1'b0;
      found      = 1'b0;
      if (cmd.init) begin
         i_in       = '0;
         k_in       = is_build ? '1 : '0;
         fail_we    = is_build;
         fail_waddr = '0;
         fail_wdata = '1;
      end else if (cmd.eval) begin
         if (hit) begin
            i_in = i_nx;
            k_in = k_nx;
            if (is_build) begin
               done    = (i_nx == tlen);
               fail_we = (i_nx != tlen);
            end else begin
               found = (k_nx[LEN_W-1:0] == plen);
               done  = found || (i_nx == tlen);
            end
         end else if (is_eq) begin
            done = 1'b1;
         end else begin
            k_in = K_W'(fail_k);
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff  <= '0;
         qry_len_ff  <= '0;
         ref_done_ff <= 1'b0;
      end else begin
         ref_len_ff  <= ref_len_in;
         qry_len_ff  <= qry_len_in;
         ref_done_ff <= ref_done_in;
      end
      i_ff <= i_in;
      k_ff <= k_in;
   end

   // Reference characters, one copy read at the text pointer, one at the pattern pointer.
   scc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ref_txt (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_waddr), .wr_data(req_char_byte),
      .rd_addr(i_addr), .rd_data(ref_txt_rd));
   scc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ref_pat (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_waddr), .wr_data(req_char_byte),
      .rd_addr(k_addr), .rd_data(ref_pat_rd));

   // Query characters, same two-copy arrangement.
   scc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_qry_txt (
      .clock(clock), .wr_en(qry_we), .wr_addr(qry_len_ff[ADDR_W-1:0]),
      .wr_data(req_char_byte), .rd_addr(i_addr), .rd_data(qry_txt_rd));
   scc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_qry_pat (
      .clock(clock), .wr_en(qry_we), .wr_addr(qry_len_ff[ADDR_W-1:0]),
      .wr_data(req_char_byte), .rd_addr(k_addr), .rd_data(qry_pat_rd));

   // Failure tables, read at the pattern pointer.
   scc_ram #(.WIDTH(FAIL_W), .DEPTH(MAX_LEN)) u_ref_fail (
      .clock(clock), .wr_en(fail_we && (cmd.op == OP_BUILD_REF)), .wr_addr(fail_waddr),
      .wr_data(fail_wdata), .rd_addr(k_addr), .rd_data(ref_fail_rd));
   scc_ram #(.WIDTH(FAIL_W), .DEPTH(MAX_LEN)) u_qry_fail (
      .clock(clock), .wr_en(fail_we && (cmd.op == OP_BUILD_QRY)), .wr_addr(fail_waddr),
      .wr_data(fail_wdata), .rd_addr(k_addr), .rd_data(qry_fail_rd));

   // Status.
   assign status.ref_complete = ref_done_ff;
   assign status.q_longer     = (qry_len_ff > ref_len_ff);
   assign status.r_longer     = (ref_len_ff > qry_len_ff);
   assign status.done         = done;
   assign status.found        = found;

endmodule

`default_nettype wire

/* hdl/scc_controller.sv */
// Controller of the classifier: sequences loading, table builds and scans,
// and owns the result register. Depends on scc_pkg.
`default_nettype none

module scc_controller import scc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [REL_W-1:0] rsp_relation,
   output dp_cmd_type       cmd,
   input  dp_status_type    status
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_INIT   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_EVAL   = 6'b010000,
      ST_HOLD   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   op_type       op_ff, op_in;
   relation_type code_ff, code_in;
   relation_type rsp_relation_ff, rsp_relation_in;
   logic         rsp_valid_ff, rsp_valid_in;
   relation_type result_code;
   logic         req_accept, out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Relation code from the finished operation.
   always_comb begin
      unique case (op_ff)
         OP_SCAN_QT: result_code = status.found ? REL_Q_HAS_R : REL_Q_NOT_R;
         OP_SCAN_RT: result_code = status.found ? REL_R_HAS_Q : REL_R_NOT_Q;
         OP_EQ:      result_code = status.found ? REL_EQUAL : REL_DIFFER;
         default:    result_code = REL_DIFFER;
      endcase
   end

   // Next state, commands and result register.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      code_in         = code_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_relation_in = rsp_relation_ff;
      cmd             = '0;
      cmd.op          = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_REF) begin
                  cmd.load_ref = 1'b1;
                  if (req_last) begin
                     op_in    = OP_BUILD_REF;
                     state_in = ST_INIT;
                  end
               end else begin
                  cmd.load_query = 1'b1;
                  if (req_last) begin
                     if (status.ref_complete) begin
                        state_in = ST_DECIDE;
                     end else begin
                        cmd.clear_query = 1'b1;
                     end
                  end
               end
            end
         end
         ST_DECIDE: begin
            priority if (status.q_longer) begin
               op_in = OP_SCAN_QT;
            end else if (status.r_longer) begin
               op_in = OP_BUILD_QRY;
            end else begin
               op_in = OP_EQ;
            end
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.done) begin
               unique case (op_ff)
                  OP_BUILD_REF: begin
                     cmd.set_ref_complete = 1'b1;
                     state_in             = ST_IDLE;
                  end
                  OP_BUILD_QRY: begin
                     op_in    = OP_SCAN_RT;
                     state_in = ST_INIT;
                  end
                  default: begin
                     cmd.clear_query = 1'b1;
                     if (out_free) begin
                        rsp_valid_in    = 1'b1;
                        rsp_relation_in = result_code;
                        state_in        = ST_IDLE;
                     end else begin
                        code_in  = result_code;
                        state_in = ST_HOLD;
                     end
                  end
               endcase
            end else begin
               state_in = ST_READ;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_relation_in = code_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      code_ff         <= code_in;
      rsp_relation_ff <= rsp_relation_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_relation = rsp_relation_ff;

endmodule

`default_nettype wire

/* hdl/string_containment_classifier_core.sv */
// Top level of the string containment classifier: controller plus datapath.
// Depends on scc_pkg, scc_controller, scc_datapath.
//
//   channel  direction  ports                                    carries
//   req      in         req_valid req_stall req_kind              one string byte
//                       req_char_byte req_last
//   rsp      out        rsp_valid rsp_stall rsp_relation          one relation code
//
// A byte that does not end a string starts no work. A reference's last byte starts
// its failure-table build; a query's last byte, with a reference complete, starts
// its compare or scan, preceded by a query-table build when the reference is longer.
// Each build or scan takes at most twice the length it walks in KMP steps, each
// step a registered memory read followed by a compare.
// Reset is synchronous and clears only control state; the memories are not cleared.
// req_stall is high while a build or search runs or a finished result cannot yet be
// sent; a result already on rsp is held while stalled, and bytes are still taken.
`default_nettype none

module string_containment_classifier_core import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [CHAR_W-1:0] req_char_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [REL_W-1:0]  rsp_relation
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing and result register.
   scc_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_relation (rsp_relation),
      .cmd          (cmd),
      .status       (status)
   );

   // Memories and KMP step logic.
   scc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_char_byte (req_char_byte),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

/* hdl/scc_checker.sv */
// Port-level checks of the string containment classifier and their binding.
// Depends on scc_pkg and string_containment_classifier_core_defines.svh.
`default_nettype none
`include "string_containment_classifier_core_defines.svh"

module scc_checker import scc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_kind,
   input logic [CHAR_W-1:0] req_char_byte,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [REL_W-1:0]  rsp_relation
);

   logic req_take;
   logic ref_end_take;

   assign req_take     = req_valid && !req_stall && (req_char_byte == req_char_byte);
   assign ref_end_take = req_take && (req_kind == KIND_REF) && req_last;

   // A finished reference always starts a table build.
   `SCC_ASSERT_NEXT(a_ref_last_builds, clock, reset, ref_end_take, req_stall)

   // A byte inside a string never starts work.
   `SCC_ASSERT_NEXT(a_mid_byte_idle, clock, reset, req_take && !req_last, !req_stall)

   // A result appears only at the end of a search, while input is held off.
   `SCC_ASSERT_NOW(a_result_after_search, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A stalled result holds its code.
   `SCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_relation))

   // Reset leaves no result pending.
   `SCC_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid)

endmodule

bind string_containment_classifier_core scc_checker u_scc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_kind      (req_kind),
   .req_char_byte (req_char_byte),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_relation  (rsp_relation)
);

`default_nettype wire

/* tb/string_containment_classifier_core_tb.sv */
// Self-checking testbench for string_containment_classifier_core: drives reference and
// query bytes, predicts each relation code with a KMP search of its own and checks them.
// Depends on scc_pkg and the string_containment_classifier_core RTL.
`timescale 1ns / 100ps

module string_containment_classifier_core_tb;
   import scc_pkg::*;

   localparam logic KIND_QUERY = ~KIND_REF;
   // The whole run stays well under this limit.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 10_000;
   localparam int SHORT_BYTES_PER_PHASE = 60;
   localparam int MAX_REPORTS = 10;

   // One row of the directed table; want is only used where is_typed is set.
   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              is_typed;
      relation_type      want;
   } stim_row_type;

   localparam int NUM_ROWS = 24;
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      // A query with no reference loaded yields nothing.
      '{KIND_QUERY, 8'h41, 1'b1, 1'b0, REL_EQUAL},
      // Reference {00, FF}.
      '{KIND_REF,   8'h00, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_REF,   8'hFF, 1'b1, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h00, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'hFF, 1'b1, 1'b1, REL_EQUAL},
      '{KIND_QUERY, 8'hFF, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h00, 1'b1, 1'b1, REL_DIFFER},
      '{KIND_QUERY, 8'h00, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'hFF, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h00, 1'b1, 1'b1, REL_Q_HAS_R},
      '{KIND_QUERY, 8'hFF, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'hFF, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h00, 1'b1, 1'b1, REL_Q_NOT_R},
      '{KIND_QUERY, 8'hFF, 1'b1, 1'b1, REL_R_HAS_Q},
      '{KIND_QUERY, 8'h01, 1'b1, 1'b1, REL_R_NOT_Q},
      // Query and a new reference interleaved.
      '{KIND_QUERY, 8'h00, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_REF,   8'h7F, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_REF,   8'h80, 1'b1, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h7F, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h80, 1'b1, 1'b0, REL_EQUAL},
      // A query ending while a new reference is incomplete is dropped.
      '{KIND_REF,   8'h55, 1'b0, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h55, 1'b1, 1'b0, REL_EQUAL},
      '{KIND_REF,   8'h55, 1'b1, 1'b0, REL_EQUAL},
      '{KIND_QUERY, 8'h55, 1'b1, 1'b1, REL_R_HAS_Q}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_kind;
   logic [CHAR_W-1:0] req_char_byte;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [REL_W-1:0]  rsp_relation;

   string_containment_classifier_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_char_byte (req_char_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_relation  (rsp_relation)
   );

   // Predicted block state.
   logic [CHAR_W-1:0] ref_store [MAX_LEN];
   logic [CHAR_W-1:0] qry_store [MAX_LEN];
   int                ref_len;
   int                qry_len;
   bit                ref_done;
   // Scratch for the search.
   logic [CHAR_W-1:0] txt_buf [MAX_LEN];
   logic [CHAR_W-1:0] pat_buf [MAX_LEN];
   int                kmp_fail [MAX_LEN + 1];

   relation_type      expected_relations [$];
   relation_type      predicted_rel;
   int                mismatches;
   int unsigned       cycle_count;
   bit                typed_on;
   relation_type      typed_rel;

   // Stimulus control.
   int                send_idle_pct;
   int                stall_pct;
   int                bytes_sent;
   logic [CHAR_W-1:0] sym_a, sym_b, sym_c;
   logic [CHAR_W-1:0] ref_text [$];
   logic [CHAR_W-1:0] qry_text [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Does the pattern in pat_buf occur in the text in txt_buf?
   function automatic bit find_pattern(int tlen, int plen);
      int i;
      int k;
      i = 0;
      k = -1;
      kmp_fail[0] = -1;
      while (i < plen) begin
         if (k < 0 || pat_buf[i] == pat_buf[k]) begin
            i++;
            k++;
            kmp_fail[i] = k;
         end else begin
            k = kmp_fail[k];
         end
      end
      i = 0;
      k = 0;
      while (i < tlen && k < plen) begin
         if (k < 0 || txt_buf[i] == pat_buf[k]) begin
            i++;
            k++;
            if (k == plen) return 1'b1;
         end else begin
            k = kmp_fail[k];
         end
      end
      return 1'b0;
   endfunction

   // Updates the predicted state for one accepted byte; returns 1 when a relation results.
   function automatic bit classify_byte(input logic kind, input logic [CHAR_W-1:0] ch,
                                        input logic last, output relation_type rel);
      int j;
      rel = REL_EQUAL;
      if (kind == KIND_REF) begin
         if (ref_done) begin
            ref_done = 1'b0;
            ref_len = 0;
         end
         if (ref_len < MAX_LEN) begin
            ref_store[ref_len] = ch;
            ref_len++;
         end
         if (last) ref_done = 1'b1;
         return 1'b0;
      end
      if (qry_len < MAX_LEN) begin
         qry_store[qry_len] = ch;
         qry_len++;
      end
      if (!last) return 1'b0;
      if (!ref_done) begin
         qry_len = 0;
         return 1'b0;
      end
      if (ref_len < qry_len) begin
         for (j = 0; j < qry_len; j++) txt_buf[j] = qry_store[j];
         for (j = 0; j < ref_len; j++) pat_buf[j] = ref_store[j];
         rel = find_pattern(qry_len, ref_len) ? REL_Q_HAS_R : REL_Q_NOT_R;
      end else if (ref_len > qry_len) begin
         for (j = 0; j < ref_len; j++) txt_buf[j] = ref_store[j];
         for (j = 0; j < qry_len; j++) pat_buf[j] = qry_store[j];
         rel = find_pattern(ref_len, qry_len) ? REL_R_HAS_Q : REL_R_NOT_Q;
      end else begin
         rel = REL_EQUAL;
         for (j = 0; j < qry_len; j++)
            if (qry_store[j] != ref_store[j]) rel = REL_DIFFER;
      end
      qry_len = 0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                  cycle_count, what, want, got);
   endtask

   // Check results against the oldest expectation, then predict from accepted bytes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_relations.size() == 0)
               report_mismatch("relation with none expected", -1, rsp_relation);
            else if (rsp_relation !== expected_relations[0])
               report_mismatch("relation", expected_relations.pop_front(), rsp_relation);
            else
               void'(expected_relations.pop_front());
         end
         if (req_valid && !req_stall) begin
            if (classify_byte(req_kind, req_char_byte, req_last, predicted_rel))
               expected_relations.push_back(typed_on ? typed_rel : predicted_rel);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Random result-side stalls.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Presents one item at a falling edge and holds it until it is taken.
   task automatic send_byte(input logic kind, input logic [CHAR_W-1:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_char_byte <= ch;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(bit is_query);
      int j;
      int n;
      n = is_query ? qry_text.size() : ref_text.size();
      for (j = 0; j < n; j++) begin
         if (is_query) send_byte(KIND_QUERY, qry_text[j], j == n - 1);
         else send_byte(KIND_REF, ref_text[j], j == n - 1);
      end
   endtask

   // Sends the pending reference and query with their bytes shuffled together.
   task automatic send_mixed();
      int ri;
      int qi;
      ri = 0;
      qi = 0;
      while (ri < ref_text.size() || qi < qry_text.size()) begin
         if (qi >= qry_text.size() || (ri < ref_text.size() && $urandom_range(1))) begin
            send_byte(KIND_REF, ref_text[ri], ri == ref_text.size() - 1);
            ri++;
         end else begin
            send_byte(KIND_QUERY, qry_text[qi], qi == qry_text.size() - 1);
            qi++;
         end
      end
   endtask

   task automatic pick_symbols();
      sym_a = $urandom_range(255);
      sym_b = $urandom_range(255);
      sym_c = $urandom_range(255);
   endtask

   // Appends characters, either any byte or mostly two symbols so that matches occur.
   task automatic add_chars(bit to_query, int n, bit wide);
      logic [CHAR_W-1:0] c;
      repeat (n) begin
         if (wide) c = $urandom_range(255);
         else if ($urandom_range(3) == 0) c = sym_c;
         else c = $urandom_range(1) ? sym_a : sym_b;
         if (to_query) qry_text.push_back(c);
         else ref_text.push_back(c);
      end
   endtask

   // Builds a query related to the current reference in one of several ways.
   task automatic make_query(bit wide);
      int n;
      int start;
      int len;
      int j;
      n = ref_text.size();
      qry_text.delete();
      case ($urandom_range(5))
         0: add_chars(1'b1, $urandom_range(1, 14), wide);
         1: begin
            start = $urandom_range(n - 1);
            len = $urandom_range(1, n - start);
            for (j = start; j < start + len; j++) qry_text.push_back(ref_text[j]);
         end
         2: qry_text = ref_text;
         3: begin
            qry_text = ref_text;
            j = $urandom_range(n - 1);
            qry_text[j] = qry_text[j] ^ (8'd1 << $urandom_range(7));
         end
         4: begin
            add_chars(1'b1, $urandom_range(3), wide);
            for (j = 0; j < n; j++) qry_text.push_back(ref_text[j]);
            add_chars(1'b1, $urandom_range(3), wide);
         end
         default: begin
            len = n - 1 + $urandom_range(2);
            if (len < 1) len = 1;
            add_chars(1'b1, len, wide);
         end
      endcase
   endtask

   // Strings beyond the store size, where both lengths saturate.
   task automatic long_session(int extra);
      int j;
      int len;
      pick_symbols();
      ref_text.delete();
      add_chars(1'b0, MAX_LEN + extra, 1'b0);
      send_text(1'b0);
      // Same bytes up to a length past the store size, sometimes with one byte changed.
      qry_text = ref_text;
      len = MAX_LEN + 1 + $urandom_range(1);
      while (qry_text.size() > len) void'(qry_text.pop_back());
      if (qry_text.size() < len) add_chars(1'b1, len - qry_text.size(), 1'b0);
      if ($urandom_range(1)) begin
         j = $urandom_range(len - 1);
         qry_text[j] = qry_text[j] ^ (8'd1 << $urandom_range(7));
      end
      send_text(1'b1);
      // A short piece of the long reference.
      qry_text.delete();
      j = $urandom_range(MAX_LEN - 8);
      len = $urandom_range(4, 8);
      for (int i = j; i < j + len; i++) qry_text.push_back(ref_text[i]);
      send_text(1'b1);
      // A short reference for the short strings that follow.
      ref_text.delete();
      add_chars(1'b0, $urandom_range(3, 6), 1'b0);
      send_text(1'b0);
   endtask

   initial begin
      int phase;
      int phase_end;
      int pick;
      bit wide;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_REF;
      req_char_byte = '0;
      req_last      = 1'b0;
      rsp_stall     = 1'b0;
      ref_len       = 0;
      qry_len       = 0;
      ref_done      = 1'b0;
      mismatches    = 0;
      cycle_count   = 0;
      typed_on      = 1'b0;
      typed_rel     = REL_EQUAL;
      bytes_sent    = 0;
      send_idle_pct = 19;
      stall_pct     = 64;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 3; phase++) begin
         // Sender idles lightly first, then heavily, then not at all.
         case (phase)
            0: begin
               send_idle_pct = 19;
               stall_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
         endcase

         // Directed table, then the long strings.
         if (phase == 0) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
               typed_on  = DIRECTED[r].is_typed;
               typed_rel = DIRECTED[r].want;
               send_byte(DIRECTED[r].kind, DIRECTED[r].ch, DIRECTED[r].last);
            end
            typed_on = 1'b0;
            long_session(1);
         end

         // Short strings: mostly queries derived from the reference.
         phase_end = bytes_sent + SHORT_BYTES_PER_PHASE;
         while (bytes_sent < phase_end) begin
            wide = ($urandom_range(3) == 0);
            pick = $urandom_range(15);
            if (pick == 0) begin
               pick_symbols();
               ref_text.delete();
               add_chars(1'b0, $urandom_range(1, 10), wide);
               qry_text.delete();
               add_chars(1'b1, $urandom_range(1, 10), wide);
               send_mixed();
            end else if (pick < 4) begin
               pick_symbols();
               ref_text.delete();
               add_chars(1'b0, $urandom_range(1, 10), wide);
               send_text(1'b0);
            end else begin
               make_query(wide);
               send_text(1'b1);
            end
         end
      end
      req_valid <= 1'b0;

      while (expected_relations.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_relations.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
